// ===== sv/csvti_pkg.sv =====
`default_nettype none

package csvti_pkg;

    // Type codes for fields and columns
    typedef enum logic [2:0] {
        TY_BOOL   = 3'd0,
        TY_INT    = 3'd1,
        TY_UINT   = 3'd2,
        TY_FLOAT  = 3'd3,
        TY_STRING = 3'd4
    } field_type_t;

    localparam int MAX_COLUMNS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Input column index width and span
    localparam int COLUMN_W    = 6;
    localparam int COLUMN_SPAN = 1 << COLUMN_W;

    // Character constants
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // "true" and "false" in lower case
    localparam logic [7:0] WORD_TRUE  [4] = '{8'h74, 8'h72, 8'h75, 8'h65};
    localparam logic [7:0] WORD_FALSE [5] = '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};
    localparam logic [2:0] TRUE_LEN  = 3'd4;
    localparam logic [2:0] FALSE_LEN = 3'd5;

    // Field class from the per-field flags
    function automatic field_type_t classify(
        input logic [2:0] char_count,
        input logic       starts_with_minus,
        input logic [1:0] point_count,
        input logic       has_bad_char,
        input logic       true_match,
        input logic       false_match
    );
        field_type_t res;
        if (char_count == 3'd0)
            res = TY_STRING;
        else if ((true_match && char_count == TRUE_LEN) ||
                 (false_match && char_count == FALSE_LEN))
            res = TY_BOOL;
        else if (has_bad_char || point_count > 2'd1 ||
                 (starts_with_minus && char_count == 3'd1))
            res = TY_STRING;
        else if (point_count == 2'd0)
            res = starts_with_minus ? TY_INT : TY_UINT;
        else
            res = (char_count > 3'd1) ? TY_FLOAT : TY_STRING;
        return res;
    endfunction

    // Widen a column type by a later-row field type
    function automatic field_type_t merge(
        input field_type_t col,
        input field_type_t fld
    );
        field_type_t res;
        if (fld == col)
            res = col;
        else if (fld == TY_STRING || col == TY_BOOL || fld == TY_BOOL)
            res = TY_STRING;
        else if (fld == TY_INT && col == TY_UINT)
            res = TY_INT;
        else if (fld == TY_FLOAT && (col == TY_UINT || col == TY_INT))
            res = TY_FLOAT;
        else
            res = col;
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/csvti_front.sv =====
`default_nettype none

module csvti_front #(
    parameter int MAX_COLUMNS = csvti_pkg::MAX_COLUMNS_DEF,
    parameter int IDX_W       = 6
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // item channel
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     in_end,
    input  wire logic [7:0]               in_ch,
    input  wire logic [csvti_pkg::COLUMN_W-1:0] in_column,
    input  wire logic                     in_first_row,
    // queue push side
    output logic                          push_valid,
    input  wire logic                     push_ready,
    output csvti_pkg::field_type_t        push_fld,
    output logic                          push_first_row,
    output logic [IDX_W-1:0]              push_col
);
    import csvti_pkg::*;

    logic [2:0] char_count_reg, char_count_next;
    logic       minus_reg, minus_next;
    logic [1:0] point_count_reg, point_count_next;
    logic       bad_reg, bad_next;
    logic       true_reg, true_next;
    logic       false_reg, false_next;
    logic [7:0] low;
    logic       accept;
    logic [IDX_W-1:0] wrap_tbl [COLUMN_SPAN];

    // column index wrapped into the store depth
    for (genvar g = 0; g < COLUMN_SPAN; g++)
    begin : g_wrap
        assign wrap_tbl[g] = IDX_W'(g % MAX_COLUMNS);
    end

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    assign push_valid     = in_valid && in_end && push_ready;
    assign push_first_row = in_first_row;
    assign push_col       = wrap_tbl[in_column];
    assign push_fld       = classify(char_count_reg, minus_reg, point_count_reg,
                                     bad_reg, true_reg, false_reg);

    // per-character flag update
    always_comb
    begin
        low = (in_ch inside {[CH_UP_A:CH_UP_Z]}) ? in_ch + CASE_OFS : in_ch;
        char_count_next  = char_count_reg;
        minus_next       = minus_reg;
        point_count_next = point_count_reg;
        bad_next         = bad_reg;
        true_next        = true_reg;
        false_next       = false_reg;
        if (accept && in_end)
        begin
            char_count_next  = 3'd0;
            minus_next       = 1'b0;
            point_count_next = 2'd0;
            bad_next         = 1'b0;
            true_next        = 1'b1;
            false_next       = 1'b1;
        end
        else if (accept)
        begin
            if (char_count_reg >= TRUE_LEN || WORD_TRUE[char_count_reg[1:0]] != low)
                true_next = 1'b0;
            if (char_count_reg >= FALSE_LEN)
                false_next = 1'b0;
            else if (WORD_FALSE[char_count_reg] != low)
                false_next = 1'b0;
            if (in_ch == CH_MINUS && char_count_reg == 3'd0)
                minus_next = 1'b1;
            else if (in_ch == CH_POINT)
            begin
                if (point_count_reg != 2'd3)
                    point_count_next = point_count_reg + 2'd1;
            end
            else if (in_ch < CH_ZERO || in_ch > CH_NINE)
                bad_next = 1'b1;
            if (char_count_reg != 3'd7)
                char_count_next = char_count_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg  <= 3'd0;
            minus_reg       <= 1'b0;
            point_count_reg <= 2'd0;
            bad_reg         <= 1'b0;
            true_reg        <= 1'b1;
            false_reg       <= 1'b1;
        end
        else
        begin
            char_count_reg  <= char_count_next;
            minus_reg       <= minus_next;
            point_count_reg <= point_count_next;
            bad_reg         <= bad_next;
            true_reg        <= true_next;
            false_reg       <= false_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/csvti_fifo.sv =====
`default_nettype none

module csvti_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = csvti_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output logic [DATA_W-1:0]      rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] store [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = store[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            store[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ===== sv/csvti_back.sv =====
`default_nettype none

module csvti_back #(
    parameter int MAX_COLUMNS = csvti_pkg::MAX_COLUMNS_DEF,
    parameter int IDX_W       = 6
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // queue pop side
    input  wire logic                   pop_valid,
    output logic                        pop_ready,
    input  csvti_pkg::field_type_t      pop_fld,
    input  wire logic                   pop_first_row,
    input  wire logic [IDX_W-1:0]       pop_col,
    // result channel
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output csvti_pkg::field_type_t      out_fld,
    output csvti_pkg::field_type_t      out_col
);
    import csvti_pkg::*;

    field_type_t       col_store [MAX_COLUMNS];

    // lookup stage
    logic              stg_valid_reg;
    field_type_t       stg_fld_reg;
    logic              stg_first_reg;
    logic [IDX_W-1:0]  stg_col_reg;
    field_type_t       rd_data_reg;

    // last store write, covers the read that raced it
    logic              lw_valid_reg;
    logic [IDX_W-1:0]  lw_col_reg;
    field_type_t       lw_val_reg;

    // output register
    logic              out_valid_reg;
    field_type_t       out_fld_reg;
    field_type_t       out_col_reg;

    field_type_t       col_prev;
    field_type_t       merged;
    logic              stg_fire;
    logic              pop;

    assign stg_fire  = stg_valid_reg && (!out_valid_reg || out_ready);
    assign pop_ready = !stg_valid_reg || stg_fire;
    assign pop       = pop_valid && pop_ready;

    assign out_valid = out_valid_reg;
    assign out_fld   = out_fld_reg;
    assign out_col   = out_col_reg;

    // merge with forwarded column type
    always_comb
    begin
        col_prev = (lw_valid_reg && lw_col_reg == stg_col_reg) ? lw_val_reg : rd_data_reg;
        merged   = stg_first_reg ? stg_fld_reg : merge(col_prev, stg_fld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_ready)
                stg_valid_reg <= pop_valid;
            if (stg_fire)
                lw_valid_reg <= 1'b1;
            if (stg_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers and column store
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            stg_fld_reg   <= pop_fld;
            stg_first_reg <= pop_first_row;
            stg_col_reg   <= pop_col;
            rd_data_reg   <= col_store[pop_col];
        end
        if (stg_fire)
        begin
            col_store[stg_col_reg] <= merged;
            lw_col_reg             <= stg_col_reg;
            lw_val_reg             <= merged;
            out_fld_reg            <= stg_fld_reg;
            out_col_reg            <= merged;
        end
    end

endmodule

`default_nettype wire

// ===== sv/csv_column_type_inference_core.sv =====
// CSV column type inference core.
// Slave channel: one item per handshake. s_tlast low carries one field
// character in s_tdata[7:0]; s_tlast high closes the field, with the column
// index in s_tdata[13:8] and the first-row flag in s_tuser.
// Master channel: one item per closed field, m_tdata[2:0] the field type and
// m_tdata[5:3] the column's merged type (0 bool, 1 int, 2 uint, 3 float,
// 4 string). Character items produce no result.
// Throughput: one item per cycle on both sides while the queue has room and
// m_tready is high. A field end passes through the queue, then the lookup
// stage, where the column store read is registered, then the output register.
// The store read-modify-write is one item per cycle while the output is not
// stalled; a write in the same cycle as the next read of that column is forwarded.
// Reset clears the per-field flags, the queue, the lookup stage and the output register;
// the column store holds no reset value; first-row fields set it, later fields widen it.
// A stalled m_tready holds the result; the queue keeps taking field ends until
// it fills, after which s_tready drops.
`default_nettype none

module csv_column_type_inference_core #(
    parameter int MAX_COLUMNS = csvti_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // ch[7:0], column[13:8], zero fill
    input  wire logic        s_tlast,   // end of field
    input  wire logic [0:0]  s_tuser,   // first_row[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // field_type[2:0], column_type[5:3], zero fill
);
    import csvti_pkg::*;

    localparam int IDX_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ENTRY_W = IDX_W + 4;

    logic              push_valid, push_ready;
    field_type_t       push_fld;
    logic              push_first_row;
    logic [IDX_W-1:0]  push_col;
    logic [ENTRY_W-1:0] wr_entry, rd_entry;
    logic              pop_valid, pop_ready;
    field_type_t       out_fld, out_col;

    csvti_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .IDX_W       (IDX_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_end         (s_tlast),
        .in_ch          (s_tdata[7:0]),
        .in_column      (s_tdata[13:8]),
        .in_first_row   (s_tuser[0]),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_fld       (push_fld),
        .push_first_row (push_first_row),
        .push_col       (push_col)
    );

    assign wr_entry = {push_col, push_first_row, push_fld};

    csvti_fifo #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH_DEF)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (wr_entry),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (rd_entry)
    );

    csvti_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .IDX_W       (IDX_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_fld       (field_type_t'(rd_entry[2:0])),
        .pop_first_row (rd_entry[3]),
        .pop_col       (rd_entry[ENTRY_W-1:4]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_fld       (out_fld),
        .out_col       (out_col)
    );

    assign m_tdata = {2'b00, out_col, out_fld};

endmodule

`default_nettype wire

// ===== sv/csvti_checker.sv =====
`default_nettype none

module csvti_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);
    import csvti_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // only defined type codes leave the block
    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= TY_STRING && m_tdata[5:3] <= TY_STRING)
        else $error("undefined type code");

    // a string field always leaves a string column
    a_string: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] == TY_STRING |-> m_tdata[5:3] == TY_STRING)
        else $error("string field did not widen column to string");

    // a bool field leaves bool or string
    a_bool: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] == TY_BOOL |->
            m_tdata[5:3] == TY_BOOL || m_tdata[5:3] == TY_STRING)
        else $error("bool field merged into a number column");

    // a float field leaves float or string
    a_float: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] == TY_FLOAT |->
            m_tdata[5:3] == TY_FLOAT || m_tdata[5:3] == TY_STRING)
        else $error("float field narrowed the column");

endmodule

bind csv_column_type_inference_core csvti_checker u_csvti_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/csv_column_type_inference_core_test.sv =====
`default_nettype none

module csv_column_type_inference_core_test;
    import csvti_pkg::*;

    typedef logic [7:0] text_t[$];

    typedef struct packed {
        field_type_t fld;
        field_type_t col;
    } type_pair_t;

    // Predicts field and column types and checks the result stream
    class type_scoreboard;
        logic [2:0]  n_chars;
        logic        lead_minus;
        logic [1:0]  n_points;
        logic        bad_char;
        logic        maybe_true;
        logic        maybe_false;
        field_type_t col_types[MAX_COLUMNS_DEF];
        type_pair_t  expected_types[$];
        int          errors;

        function new();
            errors = 0;
            clear_field();
        endfunction

        function void clear_field();
            n_chars     = 3'd0;
            lead_minus  = 1'b0;
            n_points    = 2'd0;
            bad_char    = 1'b0;
            maybe_true  = 1'b1;
            maybe_false = 1'b1;
        endfunction

        task report(input string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        // Per-character flag update
        function void take_char(input logic [7:0] c);
            logic [2:0] pos;
            logic [7:0] low;
            pos = n_chars;
            low = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
            if (pos >= TRUE_LEN)
                maybe_true = 1'b0;
            else if (WORD_TRUE[pos[1:0]] != low)
                maybe_true = 1'b0;
            if (pos >= FALSE_LEN)
                maybe_false = 1'b0;
            else if (WORD_FALSE[pos] != low)
                maybe_false = 1'b0;
            if (c == CH_MINUS && pos == 3'd0)
                lead_minus = 1'b1;
            else if (c == CH_POINT) begin
                if (n_points != 2'd3)
                    n_points = n_points + 2'd1;
            end
            else if (c < CH_ZERO || c > CH_NINE)
                bad_char = 1'b1;
            if (n_chars != 3'd7)
                n_chars = n_chars + 3'd1;
        endfunction

        function field_type_t field_class();
            if (n_chars == 3'd0)
                return TY_STRING;
            if ((maybe_true && n_chars == TRUE_LEN) || (maybe_false && n_chars == FALSE_LEN))
                return TY_BOOL;
            if (bad_char || n_points > 2'd1 || (lead_minus && n_chars == 3'd1))
                return TY_STRING;
            if (n_points == 2'd0)
                return lead_minus ? TY_INT : TY_UINT;
            return (n_chars > 3'd1) ? TY_FLOAT : TY_STRING;
        endfunction

        // Later-row widening of a column type
        function field_type_t widen_column(input field_type_t col, input field_type_t fld);
            if (fld == col)
                return col;
            if (fld == TY_STRING || fld == TY_BOOL || col == TY_BOOL)
                return TY_STRING;
            if (col == TY_UINT && fld == TY_INT)
                return TY_INT;
            if ((col == TY_UINT || col == TY_INT) && fld == TY_FLOAT)
                return TY_FLOAT;
            return col;
        endfunction

        function void note_item(input logic last, input logic [15:0] data, input logic first);
            type_pair_t  pair;
            logic [5:0]  idx;
            if (!last)
                take_char(data[7:0]);
            else begin
                idx      = data[13:8];
                pair.fld = field_class();
                pair.col = first ? pair.fld : widen_column(col_types[idx], pair.fld);
                col_types[idx] = pair.col;
                expected_types.push_back(pair);
                clear_field();
            end
        endfunction

        task check_result(input logic [7:0] data);
            type_pair_t exp_pair;
            if (expected_types.size() == 0)
                report($sformatf("result %02h with no field pending", data));
            else begin
                exp_pair = expected_types.pop_front();
                if (data[2:0] !== exp_pair.fld)
                    report($sformatf("field_type %0d, expected %0d", data[2:0], exp_pair.fld));
                if (data[5:3] !== exp_pair.col)
                    report($sformatf("column_type %0d, expected %0d", data[5:3], exp_pair.col));
            end
        endtask
    endclass

    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 290;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic        s_tlast = 1'b0;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    type_scoreboard sb = new();

    int          gap_pct = 0;
    int          stall_pct = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    logic [63:0] written = '0;
    logic        took_in;
    logic        took_out;

    csv_column_type_inference_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // Result side backpressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Monitor both channels and watch for a hang
    always @(posedge clk) begin
        if (rst_n) begin
            took_in  = s_tvalid && s_tready;
            took_out = m_tvalid && m_tready;
            if (took_in)
                sb.note_item(s_tlast, s_tdata, s_tuser[0]);
            if (took_out)
                sb.check_result(m_tdata);
            if (took_in || took_out)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("csv_column_type_inference_core_test: FAIL");
                $finish;
            end
        end
    end

    // One item on the slave channel, with an optional gap before it
    task automatic send_item(input logic last, input logic [7:0] ch, input logic [5:0] col,
                             input logic first);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, col, ch};
        s_tlast  <= last;
        s_tuser  <= first;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Characters of a field, then the field end; never read an unwritten column
    task automatic send_field(input text_t text, input logic [5:0] col, input logic first);
        logic fr;
        fr = first;
        foreach (text[i])
            send_item(1'b0, text[i], 6'($urandom), 1'($urandom));
        if (!written[col])
            fr = 1'b1;
        written[col] = 1'b1;
        send_item(1'b1, 8'($urandom), col, fr);
    endtask

    function automatic text_t from_str(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        return t;
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic text_t rand_digits(input int lo, input int hi);
        text_t t;
        int    n;
        n = $urandom_range(hi, lo);
        repeat (n)
            t.push_back(rand_digit());
        return t;
    endfunction

    // Random field text: mostly well-formed values, some near misses and noise
    function automatic text_t random_field();
        text_t t;
        text_t tail;
        string word;
        int    pick;
        int    pos;
        pick = $urandom_range(11);
        case (pick)
            0, 1: t = rand_digits(1, 9);
            2: begin
                t = rand_digits(1, 8);
                t.push_front(CH_MINUS);
            end
            3, 4: begin
                t = rand_digits(0, 4);
                t.push_back(CH_POINT);
                tail = rand_digits(0, 4);
                foreach (tail[i])
                    t.push_back(tail[i]);
                if ($urandom_range(3) == 0)
                    t.push_front(CH_MINUS);
            end
            5, 6: begin
                word = $urandom_range(1) ? "true" : "false";
                t = from_str(word);
                foreach (t[i])
                    if ($urandom_range(1))
                        t[i] = t[i] - CASE_OFS;
                // near misses: cut, extended or one letter changed
                if (pick == 6) begin
                    case ($urandom_range(2))
                        0: void'(t.pop_back());
                        1: t.push_back(8'h61 + 8'($urandom_range(25)));
                        default: begin
                            pos = $urandom_range(t.size() - 1);
                            t[pos] = 8'h61 + 8'($urandom_range(25));
                        end
                    endcase
                end
            end
            7: begin
                case ($urandom_range(4))
                    0: t = {};
                    1: t = from_str("-");
                    2: t = from_str(".");
                    3: t = from_str("-.");
                    default: t = from_str("..");
                endcase
            end
            8: begin
                repeat ($urandom_range(9))
                    t.push_back(8'($urandom));
            end
            9: begin
                t = rand_digits(1, 5);
                pos = $urandom_range(t.size());
                case ($urandom_range(2))
                    0: t.insert(pos, 8'($urandom));
                    1: t.insert(pos, CH_MINUS);
                    default: begin
                        t.insert(pos, CH_POINT);
                        t.push_back(CH_POINT);
                    end
                endcase
            end
            10: begin
                t = rand_digits(6, 14);
                if ($urandom_range(1))
                    t[$urandom_range(t.size() - 1)] = CH_POINT;
            end
            default: begin
                repeat ($urandom_range(7, 1)) begin
                    pos = $urandom_range(11);
                    t.push_back(pos == 10 ? CH_MINUS : (pos == 11 ? CH_POINT : rand_digit()));
                end
            end
        endcase
        return t;
    endfunction

    // Stimulus
    initial begin
        int target;
        int base_gap;
        int base_stall;
        logic [5:0] col;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed fields: bool words in both cases, empty, minus alone,
        // lone point, zero byte and top byte, and widening
        send_field(from_str("tRuE"), 6'd0, 1'b1);
        send_field(from_str("FALSE"), 6'd63, 1'b1);
        send_field(from_str(""), 6'd1, 1'b1);
        send_field(from_str("-5"), 6'd2, 1'b1);
        send_field(from_str("7"), 6'd2, 1'b0);
        send_field(from_str("1."), 6'd2, 1'b0);
        send_field(from_str("."), 6'd3, 1'b1);
        send_field(from_str("-"), 6'd4, 1'b1);
        send_field(text_t'{8'h00}, 6'd5, 1'b1);
        send_field(text_t'{8'hFF}, 6'd5, 1'b0);

        // Random phases: no idling, sender gaps, receiver stalls, both
        target = items_sent;
        for (int phase = 0; phase < 4; phase++) begin
            base_gap   = (phase == 1) ? 47 : (phase == 3) ? 17 : 0;
            base_stall = (phase == 2) ? 47 : (phase == 3) ? 17 : 0;
            target += PHASE_ITEMS;
            while (items_sent < target) begin
                // occasional stretch with no idling at all
                if ($urandom_range(3) == 0) begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                else begin
                    gap_pct   = base_gap;
                    stall_pct = base_stall;
                end
                repeat (8) begin
                    col = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(7));
                    send_field(random_field(), col, $urandom_range(99) < 15);
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for the result pipeline
        while (sb.expected_types.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("csv_column_type_inference_core_test: PASS");
        else
            $display("csv_column_type_inference_core_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
